// ===== design/fix_frame_validator_assert.svh =====
// Assertion macros for the FIX frame validator.
// FFV_ASSERT_IMP checks a same-cycle implication, FFV_ASSERT_NXT a next-cycle one.
`ifndef FIX_FRAME_VALIDATOR_ASSERT_SVH
`define FIX_FRAME_VALIDATOR_ASSERT_SVH

`ifndef SYNTH
`define FFV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define FFV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FFV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/ffv_pkg.sv =====
package ffv_pkg;

    localparam int MAX_TAG_DEF    = 8191;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EQ_BYTE  = 8'h3D;

    localparam int TAG_BEGIN    = 8;
    localparam int TAG_LENGTH   = 9;
    localparam int TAG_CHECKSUM = 10;
    localparam int TAG_MSGTYPE  = 35;

    // verdict codes on the result channel
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_MALFORMED    = 2'd1,
        ST_BAD_LENGTH   = 2'd2,
        ST_BAD_CHECKSUM = 2'd3
    } status_t;

    // requests from the parser to the seen-tag table
    typedef struct packed {
        logic lookup;   // check and mark the tag on the address port
        logic msg_end;  // last beat of a message accepted
    } tbl_req_t;

    // answers from the seen-tag table
    typedef struct packed {
        logic busy;     // clearing sweep in progress
        logic dup;      // tag looked up last cycle was already seen
    } tbl_stat_t;

endpackage

// ===== design/ffv_tag_table.sv =====
module ffv_tag_table #(
    parameter int MAX_TAG = ffv_pkg::MAX_TAG_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ffv_pkg::tbl_req_t              req,
    input  logic [$clog2(MAX_TAG+1)-1:0]   addr,
    output ffv_pkg::tbl_stat_t             stat
);

    localparam int AW      = $clog2(MAX_TAG + 1);
    localparam int DEPTH   = MAX_TAG + 1;
    localparam int EPOCH_W = 16;

    // each entry holds the epoch of the message that last marked it
    logic [EPOCH_W-1:0] mem [DEPTH];

    logic [EPOCH_W-1:0] rdata_reg;
    logic [AW-1:0]      hold_addr_reg;
    logic               pend_reg;
    logic               clear_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [EPOCH_W-1:0] wr_data;

    // the sweep and a pending mark never share a cycle
    assign wr_en   = clear_reg | pend_reg;
    assign wr_addr = clear_reg ? clr_addr_reg : hold_addr_reg;
    assign wr_data = clear_reg ? '0 : epoch_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.lookup) begin
            rdata_reg     <= mem[addr];
            hold_addr_reg <= addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            epoch_reg    <= EPOCH_W'(1);
        end else begin
            pend_reg <= req.lookup;
            if (clear_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_TAG)) begin
                    clear_reg <= 1'b0;
                end
            end
            if (req.msg_end) begin
                // epoch zero is the cleared mark; on wrap, sweep again
                if (epoch_reg == '1) begin
                    clear_reg    <= 1'b1;
                    clr_addr_reg <= '0;
                    epoch_reg    <= EPOCH_W'(1);
                end else begin
                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                end
            end
        end
    end

    assign stat.busy = clear_reg;
    assign stat.dup  = pend_reg && (rdata_reg == epoch_reg);

endmodule

// ===== design/fix_frame_validator.sv =====
// FIX frame validator. Feed one message byte per beat on the s_ channel with
// s_tlast on its final byte; one status beat leaves on the m_ channel for each
// message, from a registered result buffer. The block takes one byte every cycle
// while s_tready is high. Duplicate tags are caught in a seen-tag memory of
// MAX_TAG+1 entries with a registered read: the tag is looked up on the '=' byte
// and marked on the next cycle, and since two '=' lookups are always at least
// three bytes apart the read-modify-write needs no forwarding. Each message gets
// a 16-bit epoch instead of a clear, so s_tready drops for a sweep of all
// MAX_TAG+1 entries after reset and again after every 65535 messages. A two-deep
// result buffer lets bytes keep flowing while a status waits; s_tready also
// drops while both entries are full.
module fix_frame_validator #(
    parameter int MAX_TAG    = ffv_pkg::MAX_TAG_DEF,
    parameter int COUNT_BITS = ffv_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_req
    input  logic        s_tlast,   // last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [9:2] computed_checksum,
                                   // [41:10] measured_body_length, [47:42] zero
);

    localparam int TW = $clog2(MAX_TAG + 2);
    localparam int AW = $clog2(MAX_TAG + 1);
    localparam int CB = COUNT_BITS;
    localparam int RW = 42;

    // parser state
    logic          in_value_reg,    in_value_next;
    logic [TW-1:0] tag_acc_reg,     tag_acc_next;
    logic          has_digit_reg,   has_digit_next;
    logic [TW-1:0] cur_tag_reg,     cur_tag_next;
    logic          malformed_reg,   malformed_next;
    logic [3:0]    req_seen_reg,    req_seen_next;
    logic [CB-1:0] byte_count_reg,  byte_count_next;
    logic [7:0]    sum_reg,         sum_next;
    logic [7:0]    start_sum_reg,   start_sum_next;
    logic [7:0]    frozen_sum_reg,  frozen_sum_next;
    logic          frozen_reg,      frozen_next;
    logic [CB-1:0] field_start_reg, field_start_next;
    logic [CB-1:0] len_end_reg,     len_end_next;
    logic [CB-1:0] trailer_reg,     trailer_next;
    logic [CB-1:0] decl_len_reg,    decl_len_next;
    logic [31:0]   decl_csum_reg,   decl_csum_next;
    logic          stopped_reg,     stopped_next;

    // result buffer: output stage plus skid stage
    logic          out_v_reg;
    logic [RW-1:0] out_reg;
    logic          skid_v_reg;
    logic [RW-1:0] skid_reg;

    logic          accept;
    logic          msg_done;
    logic          pop;
    logic [7:0]    b;
    logic          is_digit;
    logic [3:0]    digit;
    logic          tag_ok;
    logic          lookup;
    logic [TW+3:0] tag_ext;
    logic [TW+3:0] tag_prod;
    logic [CB+3:0] len_ext;
    logic [CB+3:0] len_prod;
    logic [35:0]   csum_ext;
    logic [35:0]   csum_prod;
    logic [CB-1:0] diff;
    logic [CB+31:0] meas_ext;
    ffv_pkg::status_t status;
    logic [7:0]    res_csum;
    logic [31:0]   res_meas;
    logic [RW-1:0] res;

    ffv_pkg::tbl_req_t  tbl_req;
    ffv_pkg::tbl_stat_t tbl_stat;

    assign s_tready = !tbl_stat.busy && !skid_v_reg;
    assign accept   = s_tvalid && s_tready;
    assign msg_done = accept && s_tlast;
    assign pop      = out_v_reg && m_tready;

    assign b        = s_tdata;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign digit    = b[3:0];
    assign tag_ok   = has_digit_reg && (tag_acc_reg <= TW'(MAX_TAG));

    // times ten plus digit, as shifts and adds
    assign tag_ext   = {4'b0, tag_acc_reg};
    assign tag_prod  = (tag_ext << 3) + (tag_ext << 1) + {{TW{1'b0}}, digit};
    assign len_ext   = {4'b0, decl_len_reg};
    assign len_prod  = (len_ext << 3) + (len_ext << 1) + {{CB{1'b0}}, digit};
    assign csum_ext  = {4'b0, decl_csum_reg};
    assign csum_prod = (csum_ext << 3) + (csum_ext << 1) + {32'b0, digit};

    // mark only on a non-last beat; a message ending on '=' is malformed anyway
    assign lookup = accept && !in_value_reg && (b == ffv_pkg::EQ_BYTE) && tag_ok
                    && !s_tlast;

    assign tbl_req.lookup  = lookup;
    assign tbl_req.msg_end = msg_done;

    ffv_tag_table #(
        .MAX_TAG (MAX_TAG)
    ) u_tag_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .addr    (tag_acc_reg[AW-1:0]),
        .stat    (tbl_stat)
    );

    always_comb begin
        in_value_next    = in_value_reg;
        tag_acc_next     = tag_acc_reg;
        has_digit_next   = has_digit_reg;
        cur_tag_next     = cur_tag_reg;
        // a duplicate found by last cycle's lookup folds in here
        malformed_next   = malformed_reg | tbl_stat.dup;
        req_seen_next    = req_seen_reg;
        byte_count_next  = byte_count_reg;
        sum_next         = sum_reg;
        start_sum_next   = start_sum_reg;
        frozen_sum_next  = frozen_sum_reg;
        frozen_next      = frozen_reg;
        field_start_next = field_start_reg;
        len_end_next     = len_end_reg;
        trailer_next     = trailer_reg;
        decl_len_next    = decl_len_reg;
        decl_csum_next   = decl_csum_reg;
        stopped_next     = stopped_reg;

        if (accept) begin
            if (byte_count_reg != '1) begin
                byte_count_next = byte_count_reg + CB'(1);
            end
            sum_next = sum_reg + b;

            if (!in_value_reg) begin
                if (is_digit) begin
                    if (tag_acc_reg <= TW'(MAX_TAG)) begin
                        if (tag_prod > (TW+4)'(MAX_TAG)) begin
                            tag_acc_next = TW'(MAX_TAG + 1);
                        end else begin
                            tag_acc_next = tag_prod[TW-1:0];
                        end
                    end
                    has_digit_next = 1'b1;
                end else if (b == ffv_pkg::EQ_BYTE) begin
                    if (!tag_ok) begin
                        malformed_next = 1'b1;
                    end else begin
                        if (tag_acc_reg == TW'(ffv_pkg::TAG_BEGIN)) begin
                            req_seen_next[0] = 1'b1;
                        end
                        if (tag_acc_reg == TW'(ffv_pkg::TAG_LENGTH)) begin
                            req_seen_next[1] = 1'b1;
                            decl_len_next    = '0;
                        end
                        if (tag_acc_reg == TW'(ffv_pkg::TAG_MSGTYPE)) begin
                            req_seen_next[2] = 1'b1;
                        end
                        if (tag_acc_reg == TW'(ffv_pkg::TAG_CHECKSUM)) begin
                            req_seen_next[3] = 1'b1;
                            decl_csum_next   = '0;
                            // freeze the sum and position at the first trailer
                            if (!frozen_reg) begin
                                frozen_next     = 1'b1;
                                frozen_sum_next = start_sum_reg;
                                trailer_next    = field_start_reg;
                            end
                        end
                    end
                    cur_tag_next  = tag_acc_reg;
                    stopped_next  = 1'b0;
                    in_value_next = 1'b1;
                end else begin
                    malformed_next = 1'b1;
                    if (b == ffv_pkg::SOH_BYTE) begin
                        in_value_next    = 1'b0;
                        tag_acc_next     = '0;
                        has_digit_next   = 1'b0;
                        field_start_next = byte_count_next;
                        start_sum_next   = sum_next;
                    end
                end
            end else if (b == ffv_pkg::SOH_BYTE) begin
                if (cur_tag_reg == TW'(ffv_pkg::TAG_LENGTH)) begin
                    len_end_next = byte_count_next;
                end
                in_value_next    = 1'b0;
                tag_acc_next     = '0;
                has_digit_next   = 1'b0;
                field_start_next = byte_count_next;
                start_sum_next   = sum_next;
            end else if ((cur_tag_reg == TW'(ffv_pkg::TAG_LENGTH) ||
                          cur_tag_reg == TW'(ffv_pkg::TAG_CHECKSUM)) && !stopped_reg) begin
                if (!is_digit) begin
                    stopped_next = 1'b1;
                end else if (cur_tag_reg == TW'(ffv_pkg::TAG_LENGTH)) begin
                    // saturate the declared length at the counter's ceiling
                    decl_len_next = (len_prod[CB+3:CB] != 4'b0) ? '1 : len_prod[CB-1:0];
                end else begin
                    decl_csum_next = (csum_prod[35:32] != 4'b0) ? '1 : csum_prod[31:0];
                end
            end
        end

        // verdict on the last byte, from the state this byte leaves
        diff     = trailer_next - len_end_next;
        meas_ext = {32'b0, diff};
        if (malformed_next || (byte_count_next < CB'(3)) || (b != ffv_pkg::SOH_BYTE) ||
            (req_seen_next != 4'hF)) begin
            status   = ffv_pkg::ST_MALFORMED;
            res_csum = 8'h00;
            res_meas = 32'h0;
        end else begin
            res_csum = frozen_sum_next;
            res_meas = meas_ext[31:0];
            if (decl_len_next != diff) begin
                status = ffv_pkg::ST_BAD_LENGTH;
            end else if (decl_csum_next != {24'b0, frozen_sum_next}) begin
                status = ffv_pkg::ST_BAD_CHECKSUM;
            end else begin
                status = ffv_pkg::ST_OK;
            end
        end
        res = {res_meas, res_csum, status};

        // the message is done: start the next one from a clean slate
        if (msg_done) begin
            in_value_next    = 1'b0;
            tag_acc_next     = '0;
            has_digit_next   = 1'b0;
            cur_tag_next     = '0;
            malformed_next   = 1'b0;
            req_seen_next    = '0;
            byte_count_next  = '0;
            sum_next         = '0;
            start_sum_next   = '0;
            frozen_sum_next  = '0;
            frozen_next      = 1'b0;
            field_start_next = '0;
            len_end_next     = '0;
            trailer_next     = '0;
            decl_len_next    = '0;
            decl_csum_next   = '0;
            stopped_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg    <= 1'b0;
            tag_acc_reg     <= '0;
            has_digit_reg   <= 1'b0;
            cur_tag_reg     <= '0;
            malformed_reg   <= 1'b0;
            req_seen_reg    <= '0;
            byte_count_reg  <= '0;
            sum_reg         <= '0;
            start_sum_reg   <= '0;
            frozen_sum_reg  <= '0;
            frozen_reg      <= 1'b0;
            field_start_reg <= '0;
            len_end_reg     <= '0;
            trailer_reg     <= '0;
            decl_len_reg    <= '0;
            decl_csum_reg   <= '0;
            stopped_reg     <= 1'b0;
        end else begin
            in_value_reg    <= in_value_next;
            tag_acc_reg     <= tag_acc_next;
            has_digit_reg   <= has_digit_next;
            cur_tag_reg     <= cur_tag_next;
            malformed_reg   <= malformed_next;
            req_seen_reg    <= req_seen_next;
            byte_count_reg  <= byte_count_next;
            sum_reg         <= sum_next;
            start_sum_reg   <= start_sum_next;
            frozen_sum_reg  <= frozen_sum_next;
            frozen_reg      <= frozen_next;
            field_start_reg <= field_start_next;
            len_end_reg     <= len_end_next;
            trailer_reg     <= trailer_next;
            decl_len_reg    <= decl_len_next;
            decl_csum_reg   <= decl_csum_next;
            stopped_reg     <= stopped_next;
        end
    end

    // result buffer valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (pop || !out_v_reg) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= msg_done;
            end else begin
                out_v_reg <= msg_done;
            end
        end else if (msg_done) begin
            skid_v_reg <= 1'b1;
        end
    end

    // result buffer payload: advance skid into output, park new results behind
    always_ff @(posedge aclk) begin
        if (pop || !out_v_reg) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
                if (msg_done) begin
                    skid_reg <= res;
                end
            end else begin
                out_reg <= res;
            end
        end else if (msg_done) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, out_reg};

`include "fix_frame_validator_assert.svh"

    // lookups are spaced apart, so the mark never races the next read
    `FFV_ASSERT_NXT(a_lookup_spacing, aclk, aresetn, lookup, !lookup, "back-to-back tag lookups")
    // a parked result implies the output stage is occupied
    `FFV_ASSERT_IMP(a_skid_order, aclk, aresetn, skid_v_reg, m_tvalid, "skid full with output empty")
    // no byte enters during the clearing sweep
    `FFV_ASSERT_IMP(a_sweep_stall, aclk, aresetn, tbl_stat.busy, !accept, "byte taken during sweep")
    // a malformed verdict carries zero checksum and length
    `FFV_ASSERT_IMP(a_malformed_zero, aclk, aresetn,
        m_tvalid && (m_tdata[1:0] == ffv_pkg::ST_MALFORMED), m_tdata[41:2] == 40'h0,
        "malformed result with nonzero fields")

endmodule
